[rtl/hsv2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// types and constants for the hsv to rgb pixel converter
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

    localparam int unsigned FIELD_W  = 17;
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 24;
    localparam int unsigned STAGES   = 5;

    typedef logic [FIELD_W-1:0] t_q16;
    typedef logic [CHAN_W-1:0]  t_chan;

    typedef enum logic [2:0] {
        SECT_RED_TO_YELLOW   = 3'd0,
        SECT_YELLOW_TO_GREEN = 3'd1,
        SECT_GREEN_TO_CYAN   = 3'd2,
        SECT_CYAN_TO_BLUE    = 3'd3,
        SECT_BLUE_TO_MAGENTA = 3'd4,
        SECT_MAGENTA_TO_RED  = 3'd5
    } t_sector;

endpackage

`default_nettype wire

[rtl/hsv_to_rgb_converter.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// converts one q16 hsv pixel per item into one 8-bit rgb pixel
// ----------------------------------------------------------------------------
// Usage
//   input stream  : s_axis, tdata = hue, saturation, brightness (17 bits each,
//                   unsigned q16, 65536 = 1.0), tuser = hue_undefined
//   output stream : m_axis, tdata = red, green, blue (8 bits each)
//   pipeline      : five register stages (a, b, c, d and output); an accepted
//                   item raises o_m_axis_tvalid once it has passed stages a to
//                   d into the output register, each move held during a stall
//   throughput    : one item per cycle unless stalled; the depth follows from
//                   the chain s*f, then v*(1 - s*f), then the scale by 255 and
//                   rounding, each multiply in a stage of its own
//   reset         : i_rst_n clears every stage valid bit, payload is not reset
//   stall         : while the output item waits for i_m_axis_tready, all
//                   stages hold and o_s_axis_tready is low; nothing is lost
//                   or repeated, and empty stages are filled as ready returns
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // hue, saturation, brightness, zero pad
    input  wire logic                  i_s_axis_tuser,  // hue_undefined
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata   // red, green, blue
);

    logic                w_en;
    logic [STAGES-1:0]   r_vld;

    // stage a
    t_q16         w_hue, w_sat, w_val;
    logic [19:0]  w_h6;
    logic [3:0]   w_sec_raw;
    logic [16:0]  w_f;
    logic [25:0]  w_cv_x;
    t_sector      n_a_sector;
    t_chan        n_a_cv;
    t_sector      r_a_sector;
    t_q16         r_a_v, r_a_s, r_a_f;
    logic         r_a_undef;
    t_chan        r_a_cv;

    // stage b
    logic signed [17:0]  w_oms;
    logic signed [34:0]  n_b_m;
    logic [33:0]         n_b_sf;
    logic signed [34:0]  r_b_m;
    logic [33:0]         r_b_sf;
    t_sector             r_b_sector;
    t_q16                r_b_v;
    logic                r_b_undef;
    t_chan               r_b_cv;

    // stage c
    logic signed [34:0]  n_c_t;
    logic [41:0]         w_cm_x;
    t_chan               n_c_cm;
    logic signed [34:0]  r_c_t;
    t_chan               r_c_cm;
    t_sector             r_c_sector;
    t_q16                r_c_v;
    logic                r_c_undef;
    t_chan               r_c_cv;

    // stage d
    logic signed [51:0]  n_d_n;
    logic signed [51:0]  r_d_n;
    t_chan               r_d_cm;
    t_sector             r_d_sector;
    logic                r_d_undef;
    t_chan               r_d_cv;

    // output stage
    logic [57:0]             w_cn_x;
    t_chan                   w_cn;
    logic [OUT_DATA_W-1:0]   n_out;
    logic [OUT_DATA_W-1:0]   r_out;

    assign w_en            = !r_vld[STAGES-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[STAGES-1];
    assign o_m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_s_axis_tvalid};
        end
    end

    // stage a: sector, fraction and gray channel
    assign w_hue     = i_s_axis_tdata[16:0];
    assign w_sat     = i_s_axis_tdata[33:17];
    assign w_val     = i_s_axis_tdata[50:34];
    assign w_h6      = ({1'b0, w_hue, 2'b00}) + ({2'b00, w_hue, 1'b0});
    assign w_sec_raw = w_h6[19:16];
    assign w_f       = w_sec_raw[0] ? {1'b0, w_h6[15:0]}
                                    : (17'h10000 - {1'b0, w_h6[15:0]});
    assign w_cv_x    = ({1'b0, w_val, 8'h00}) - {9'h000, w_val} + 26'h0008000;

    always_comb begin
        if (w_sec_raw >= 4'd6) begin
            n_a_sector = t_sector'(3'(w_sec_raw - 4'd6));
        end else begin
            n_a_sector = t_sector'(w_sec_raw[2:0]);
        end
        if (w_cv_x[25:24] != 2'b00) begin
            n_a_cv = '1;
        end else begin
            n_a_cv = w_cv_x[23:16];
        end
    end

    // stage b: m = v*(1-s) and s*f
    assign w_oms  = 18'sh10000 - $signed({1'b0, r_a_s});
    assign n_b_m  = $signed({1'b0, r_a_v}) * w_oms;
    assign n_b_sf = r_a_s * r_a_f;

    // stage c: 1 - s*f and the m channel
    assign n_c_t  = 35'sh100000000 - $signed({1'b0, r_b_sf});
    assign w_cm_x = ({r_b_m[33:0], 8'h00}) - {8'h00, r_b_m[33:0]} + 42'h080000000;

    always_comb begin
        if (r_b_m[34]) begin
            n_c_cm = '0;
        end else if (w_cm_x[41:40] != 2'b00) begin
            n_c_cm = '1;
        end else begin
            n_c_cm = w_cm_x[39:32];
        end
    end

    // stage d: n = v*(1 - s*f)
    assign n_d_n = $signed({1'b0, r_c_v}) * r_c_t;

    // output stage: n channel and channel order
    assign w_cn_x = ({1'b0, r_d_n[48:0], 8'h00}) - {9'h000, r_d_n[48:0]}
                    + 58'h0000800000000000;

    always_comb begin
        if (r_d_n[51]) begin
            w_cn = '0;
        end else if (w_cn_x[57:56] != 2'b00) begin
            w_cn = '1;
        end else begin
            w_cn = w_cn_x[55:48];
        end
        if (r_d_undef) begin
            n_out = {r_d_cv, r_d_cv, r_d_cv};
        end else begin
            unique case (r_d_sector)
                SECT_RED_TO_YELLOW:   n_out = {r_d_cm, w_cn, r_d_cv};
                SECT_YELLOW_TO_GREEN: n_out = {r_d_cm, r_d_cv, w_cn};
                SECT_GREEN_TO_CYAN:   n_out = {w_cn, r_d_cv, r_d_cm};
                SECT_CYAN_TO_BLUE:    n_out = {r_d_cv, w_cn, r_d_cm};
                SECT_BLUE_TO_MAGENTA: n_out = {r_d_cv, r_d_cm, w_cn};
                SECT_MAGENTA_TO_RED:  n_out = {w_cn, r_d_cm, r_d_cv};
                default:              n_out = {w_cn, r_d_cm, r_d_cv};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_sector <= n_a_sector;
            r_a_v      <= w_val;
            r_a_s      <= w_sat;
            r_a_f      <= w_f;
            r_a_undef  <= i_s_axis_tuser;
            r_a_cv     <= n_a_cv;

            r_b_m      <= n_b_m;
            r_b_sf     <= n_b_sf;
            r_b_sector <= r_a_sector;
            r_b_v      <= r_a_v;
            r_b_undef  <= r_a_undef;
            r_b_cv     <= r_a_cv;

            r_c_t      <= n_c_t;
            r_c_cm     <= n_c_cm;
            r_c_sector <= r_b_sector;
            r_c_v      <= r_b_v;
            r_c_undef  <= r_b_undef;
            r_c_cv     <= r_b_cv;

            r_d_n      <= n_d_n;
            r_d_cm     <= r_c_cm;
            r_d_sector <= r_c_sector;
            r_d_undef  <= r_c_undef;
            r_d_cv     <= r_c_cv;

            r_out      <= n_out;
        end
    end

    // an accepted item reaches the output if stages b, c, d and the output stay enabled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) ##1 w_en ##1 w_en ##1 w_en ##1 w_en
        |=> o_m_axis_tvalid)
        else $error("accepted item did not reach the output");

    // a gray item leaves with three equal channels
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[STAGES-2] && r_d_undef && w_en)
        |=> (o_m_axis_tdata[7:0] == o_m_axis_tdata[15:8])
            && (o_m_axis_tdata[15:8] == o_m_axis_tdata[23:16]))
        else $error("gray item has unequal channels");

    // a stalled output holds the whole pipeline
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(r_vld))
        else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
